### rtl/ahs_pkg.sv
package ahs_pkg;

	localparam int COORD_W   = 7;
	localparam int TILE_SHIFT = 5;
	localparam int IDX_W     = 2;
	localparam int NUM_ROWS  = 4;
	localparam int NUM_COLS  = 4;
	localparam int NUM_CELLS = NUM_ROWS * NUM_COLS;
	localparam int CELL_W    = $clog2(NUM_CELLS);
	localparam int VAL_W     = 8;
	localparam int NUM_EV_IN = 4;
	localparam int EV_W      = $clog2(NUM_EV_IN);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAP       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

	localparam logic [VAL_W-1:0] STEP_RST = 8'd32;
	localparam logic [VAL_W-1:0] CAP_RST  = 8'd255;
	localparam logic [VAL_W-1:0] THR_RST  = 8'd96;

	typedef struct packed {
		logic              re;
		logic [CELL_W-1:0] raddr;
		logic              we;
		logic [CELL_W-1:0] waddr;
		logic [VAL_W-1:0]  wdata;
	} mem_req_t;

	typedef struct packed {
		logic             motion;
		logic [VAL_W-1:0] hot_value;
		logic [IDX_W-1:0] hot_row;
		logic [IDX_W-1:0] hot_col;
	} res_t;

endpackage

### rtl/ahs_if.sv
interface ahs_batch_if;
	logic       valid;
	logic       ready;
	logic [6:0] ev0_x;
	logic [6:0] ev0_y;
	logic [6:0] ev1_x;
	logic [6:0] ev1_y;
	logic [6:0] ev2_x;
	logic [6:0] ev2_y;
	logic [6:0] ev3_x;
	logic [6:0] ev3_y;

	modport src (output valid, ev0_x, ev0_y, ev1_x, ev1_y, ev2_x, ev2_y, ev3_x, ev3_y,
		input ready);
	modport snk (input valid, ev0_x, ev0_y, ev1_x, ev1_y, ev2_x, ev2_y, ev3_x, ev3_y,
		output ready);
	modport mon (input valid, ready, ev0_x, ev0_y, ev1_x, ev1_y, ev2_x, ev2_y, ev3_x,
		ev3_y);
endinterface

interface ahs_result_if;
	logic       valid;
	logic       ready;
	logic       motion;
	logic [7:0] hot_value;
	logic [1:0] hot_row;
	logic [1:0] hot_col;

	modport src (output valid, motion, hot_value, hot_row, hot_col, input ready);
	modport snk (input valid, motion, hot_value, hot_row, hot_col, output ready);
	modport mon (input valid, ready, motion, hot_value, hot_row, hot_col);
endinterface

### rtl/ahs_ram.sv
module ahs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/ahs_seq.sv
module ahs_seq #(
	parameter int BATCH_SIZE = 4
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   start,
	output logic                                                   idle,
	input  logic [ahs_pkg::NUM_EV_IN-1:0][ahs_pkg::CELL_W-1:0]     cells,
	input  logic [ahs_pkg::VAL_W-1:0]                              step,
	input  logic [ahs_pkg::VAL_W-1:0]                              cap,
	input  logic [ahs_pkg::VAL_W-1:0]                              threshold,
	output ahs_pkg::mem_req_t                                      req,
	input  logic [ahs_pkg::VAL_W-1:0]                              rdata,
	output logic                                                   res_valid,
	input  logic                                                   res_ready,
	output ahs_pkg::res_t                                          res
);

	localparam int EV_USED = (BATCH_SIZE < ahs_pkg::NUM_EV_IN) ? BATCH_SIZE
		: ahs_pkg::NUM_EV_IN;
	localparam logic [ahs_pkg::EV_W-1:0] EV_LAST = ahs_pkg::EV_W'(EV_USED - 1);
	localparam int CNT_W = $clog2(ahs_pkg::NUM_CELLS + 1);

	typedef enum logic [2:0] {S_IDLE, S_DECAY, S_EVRD, S_EVWR, S_SCAN, S_FIN} state_t;
	typedef enum logic [1:0] {OP_DECAY, OP_EVENT, OP_SCAN} op_t;

	state_t                                             state_q;
	logic [CNT_W-1:0]                                   cnt_q;
	logic [ahs_pkg::EV_W-1:0]                           ev_q;
	logic [ahs_pkg::NUM_EV_IN-1:0][ahs_pkg::CELL_W-1:0] cells_q;
	logic                                               rd_vld_s1;
	logic [ahs_pkg::CELL_W-1:0]                         rd_addr_s1;
	op_t                                                rd_op_s1;
	logic [ahs_pkg::VAL_W-1:0]                          best_val_q;
	logic [ahs_pkg::CELL_W-1:0]                         best_idx_q;
	logic                                               res_valid_q;
	logic [ahs_pkg::VAL_W:0]                            sum;
	logic                                               rd_issue;
	logic [ahs_pkg::CELL_W-1:0]                         rd_addr;
	op_t                                                rd_op;

	assign sum = {1'b0, rdata} + {1'b0, step};

	// read issue: sweeps during decay and scan, one read per event
	always_comb begin
		rd_issue = 1'b0;
		rd_addr  = cnt_q[ahs_pkg::CELL_W-1:0];
		rd_op    = OP_DECAY;
		case (state_q)
			S_DECAY: begin
				rd_issue = !cnt_q[CNT_W-1];
				rd_op    = OP_DECAY;
			end
			S_EVRD: begin
				rd_issue = 1'b1;
				rd_addr  = cells_q[ev_q];
				rd_op    = OP_EVENT;
			end
			S_SCAN: begin
				rd_issue = !cnt_q[CNT_W-1];
				rd_op    = OP_SCAN;
			end
			default: begin
				rd_issue = 1'b0;
			end
		endcase
	end

	// write-back in the cycle after the read
	always_comb begin
		req.re    = rd_issue;
		req.raddr = rd_addr;
		req.waddr = rd_addr_s1;
		req.we    = 1'b0;
		req.wdata = rdata;
		case (rd_op_s1)
			OP_DECAY: begin
				req.we    = rd_vld_s1;
				req.wdata = rdata - (rdata >> 1);
			end
			OP_EVENT: begin
				req.we    = rd_vld_s1;
				req.wdata = (sum > {1'b0, cap}) ? cap : sum[ahs_pkg::VAL_W-1:0];
			end
			default: begin
				req.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_op_s1  <= OP_DECAY;
		end else begin
			rd_vld_s1 <= rd_issue;
			rd_op_s1  <= rd_op;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_addr;
		if (start) begin
			cells_q <= cells;
		end
		// running maximum; strict compare keeps the lowest index on ties
		if (rd_vld_s1 && rd_op_s1 == OP_SCAN) begin
			if (rd_addr_s1 == '0 || rdata > best_val_q) begin
				best_val_q <= rdata;
				best_idx_q <= rd_addr_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ev_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECAY;
						cnt_q   <= '0;
					end
				end
				S_DECAY: begin
					if (cnt_q[CNT_W-1]) begin
						state_q <= S_EVRD;
						ev_q    <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_EVRD: begin
					state_q <= S_EVWR;
				end
				S_EVWR: begin
					if (ev_q == EV_LAST) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
					end else begin
						state_q <= S_EVRD;
						ev_q    <= ev_q + 1'b1;
					end
				end
				S_SCAN: begin
					if (cnt_q[CNT_W-1]) begin
						state_q     <= S_FIN;
						res_valid_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q     <= S_IDLE;
						res_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle          = (state_q == S_IDLE);
	assign res_valid     = res_valid_q;
	assign res.motion    = (best_val_q >= threshold);
	assign res.hot_value = best_val_q;
	assign res.hot_row   = best_idx_q[ahs_pkg::CELL_W-1 -: ahs_pkg::IDX_W];
	assign res.hot_col   = best_idx_q[ahs_pkg::IDX_W-1:0];

endmodule

### rtl/activity_grid_hotspot_tracker.sv
// Activity-grid hotspot tracker. Keeps a 4x4 grid of 8-bit activity cells in a
// small RAM (cleared at reset by per-cell valid bits, no clearing pass). A batch
// is taken only while the sequencer is idle. Each accepted batch runs a decay
// sweep over the RAM port, a read-modify-write for each event, a scan for the
// hottest cell, a handoff of the result to the output register and a return to
// idle, in which the next batch is taken; the handoff stretches while the output
// register holds an untaken result.
// The result register lets a new batch be taken while the previous result is still held.
// step, cap and threshold are written through cfg_we/cfg_idx/cfg_wdata; the user must
// write them only while idle, as the block itself does not enforce it.
module activity_grid_hotspot_tracker #(
	parameter int BATCH_SIZE = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ahs_batch_if.snk                        batch,
	ahs_result_if.src                       result,
	input  logic                            cfg_we,
	input  logic [ahs_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ahs_pkg::VAL_W-1:0]       cfg_wdata
);

	logic [ahs_pkg::VAL_W-1:0]                          step_q;
	logic [ahs_pkg::VAL_W-1:0]                          cap_q;
	logic [ahs_pkg::VAL_W-1:0]                          thr_q;
	logic [ahs_pkg::NUM_CELLS-1:0]                      valid_q;
	logic                                               vmask_s1;
	logic [ahs_pkg::VAL_W-1:0]                          ram_rdata;
	logic [ahs_pkg::VAL_W-1:0]                          rdata;
	logic [ahs_pkg::NUM_EV_IN-1:0][ahs_pkg::CELL_W-1:0] cells;
	ahs_pkg::mem_req_t                                  req;
	logic                                               idle;
	logic                                               start;
	logic                                               seq_valid;
	logic                                               seq_ready;
	ahs_pkg::res_t                                      seq_res;
	logic                                               out_full_q;
	ahs_pkg::res_t                                      out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ahs_pkg::STEP_RST;
			cap_q  <= ahs_pkg::CAP_RST;
			thr_q  <= ahs_pkg::THR_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				ahs_pkg::REG_STEP:      step_q <= cfg_wdata;
				ahs_pkg::REG_CAP:       cap_q  <= cfg_wdata;
				ahs_pkg::REG_THRESHOLD: thr_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// row from y, column from x
	assign cells[0] = {batch.ev0_y[ahs_pkg::TILE_SHIFT +: ahs_pkg::IDX_W],
		batch.ev0_x[ahs_pkg::TILE_SHIFT +: ahs_pkg::IDX_W]};
	assign cells[1] = {batch.ev1_y[ahs_pkg::TILE_SHIFT +: ahs_pkg::IDX_W],
		batch.ev1_x[ahs_pkg::TILE_SHIFT +: ahs_pkg::IDX_W]};
	assign cells[2] = {batch.ev2_y[ahs_pkg::TILE_SHIFT +: ahs_pkg::IDX_W],
		batch.ev2_x[ahs_pkg::TILE_SHIFT +: ahs_pkg::IDX_W]};
	assign cells[3] = {batch.ev3_y[ahs_pkg::TILE_SHIFT +: ahs_pkg::IDX_W],
		batch.ev3_x[ahs_pkg::TILE_SHIFT +: ahs_pkg::IDX_W]};

	assign batch.ready = idle;
	assign start       = batch.valid && idle;

	// a cell never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vmask_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				vmask_s1 <= valid_q[req.raddr];
			end
		end
	end

	assign rdata = vmask_s1 ? ram_rdata : '0;

	ahs_ram #(
		.WIDTH (ahs_pkg::VAL_W),
		.DEPTH (ahs_pkg::NUM_CELLS)
	) u_ram (
		.clk   (clk),
		.we    (req.we),
		.waddr (req.waddr),
		.wdata (req.wdata),
		.re    (req.re),
		.raddr (req.raddr),
		.rdata (ram_rdata)
	);

	ahs_seq #(
		.BATCH_SIZE (BATCH_SIZE)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.idle      (idle),
		.cells     (cells),
		.step      (step_q),
		.cap       (cap_q),
		.threshold (thr_q),
		.req       (req),
		.rdata     (rdata),
		.res_valid (seq_valid),
		.res_ready (seq_ready),
		.res       (seq_res)
	);

	assign seq_ready = !out_full_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (seq_ready) begin
			out_full_q <= seq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_ready && seq_valid) begin
			out_q <= seq_res;
		end
	end

	assign result.valid     = out_full_q;
	assign result.motion    = out_q.motion;
	assign result.hot_value = out_q.hot_value;
	assign result.hot_row   = out_q.hot_row;
	assign result.hot_col   = out_q.hot_col;

endmodule

### rtl/ahs_checker.sv
module ahs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      batch_valid,
	input logic                      batch_ready,
	input logic                      result_valid,
	input logic                      result_ready,
	input logic                      motion,
	input logic [ahs_pkg::VAL_W-1:0] hot_value,
	input logic [ahs_pkg::IDX_W-1:0] hot_row,
	input logic [ahs_pkg::IDX_W-1:0] hot_col
);

	logic b_acc;

	assign b_acc = batch_valid && batch_ready;

	// accepting a batch makes the block busy, so ready drops
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		b_acc |=> !batch_ready)
		else $error("batch ready right after accepting a batch");

	// a result never appears in the cycle after a batch was taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		b_acc |=> !$rose(result_valid))
		else $error("result appeared right after batch acceptance");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before transaction");

	a_payload_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(hot_value)
		&& $stable(hot_row) && $stable(hot_col) && $stable(motion))
		else $error("stalled result payload changed");

	// a fresh result lands as the sequencer goes back to idle
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> batch_ready)
		else $error("result appeared while the block was still busy");

endmodule

bind activity_grid_hotspot_tracker ahs_checker u_ahs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.batch_valid  (batch.valid),
	.batch_ready  (batch.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.motion       (result.motion),
	.hot_value    (result.hot_value),
	.hot_row      (result.hot_row),
	.hot_col      (result.hot_col)
);

### test/activity_grid_hotspot_tracker_tb.sv
`timescale 1ns / 100ps

module activity_grid_hotspot_tracker_tb;

	localparam int BATCH_SIZE  = 4;
	localparam int EVENTS_USED = (BATCH_SIZE < ahs_pkg::NUM_EV_IN) ? BATCH_SIZE
		: ahs_pkg::NUM_EV_IN;

	typedef struct packed {
		logic [ahs_pkg::NUM_EV_IN-1:0][ahs_pkg::COORD_W-1:0] x;
		logic [ahs_pkg::NUM_EV_IN-1:0][ahs_pkg::COORD_W-1:0] y;
	} ev_batch_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [ahs_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [ahs_pkg::VAL_W-1:0]     cfg_wdata;

	ahs_batch_if  batch_ch ();
	ahs_result_if result_ch ();

	activity_grid_hotspot_tracker #(
		.BATCH_SIZE(BATCH_SIZE)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.batch    (batch_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// shadow of the grid and registers
	logic [ahs_pkg::VAL_W-1:0] grid [ahs_pkg::NUM_CELLS];
	logic [ahs_pkg::VAL_W-1:0] step_r;
	logic [ahs_pkg::VAL_W-1:0] cap_r;
	logic [ahs_pkg::VAL_W-1:0] thr_r;

	ev_batch_t     pending_batches [$];
	ahs_pkg::res_t expected_hotspots [$];
	ev_batch_t     cur_batch;
	int            send_idle;
	int            recv_idle;
	int            mismatches;
	int            results_seen;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic predict_hotspot(input ev_batch_t b, output ahs_pkg::res_t r);
		int                        tile_idx;
		int                        best_pos;
		logic [ahs_pkg::VAL_W:0]   sum;
		logic [ahs_pkg::VAL_W-1:0] best;
		logic [ahs_pkg::IDX_W-1:0] row;
		logic [ahs_pkg::IDX_W-1:0] col;
		for (int c = 0; c < ahs_pkg::NUM_CELLS; c++)
			grid[c] = grid[c] - (grid[c] >> 1);
		for (int i = 0; i < EVENTS_USED; i++) begin
			col      = ahs_pkg::IDX_W'(b.x[i] >> ahs_pkg::TILE_SHIFT);
			row      = ahs_pkg::IDX_W'(b.y[i] >> ahs_pkg::TILE_SHIFT);
			tile_idx = int'(row) * ahs_pkg::NUM_COLS + int'(col);
			sum      = {1'b0, grid[tile_idx]} + {1'b0, step_r};
			grid[tile_idx] = (sum > {1'b0, cap_r}) ? cap_r : sum[ahs_pkg::VAL_W-1:0];
		end
		best_pos = 0;
		best     = grid[0];
		for (int c = 1; c < ahs_pkg::NUM_CELLS; c++) begin
			if (grid[c] > best) begin
				best     = grid[c];
				best_pos = c;
			end
		end
		r.motion    = (best >= thr_r);
		r.hot_value = best;
		r.hot_row   = ahs_pkg::IDX_W'(best_pos / ahs_pkg::NUM_COLS);
		r.hot_col   = ahs_pkg::IDX_W'(best_pos % ahs_pkg::NUM_COLS);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: result %0d %s: got %0d, expected %0d", $realtime, results_seen,
			what, got, want);
		mismatches++;
	endtask

	// batch driver
	always @(posedge clk or negedge arst_n) begin
		ahs_pkg::res_t r;
		if (!arst_n) begin
			batch_ch.valid <= 1'b0;
			batch_ch.ev0_x <= '0;
			batch_ch.ev0_y <= '0;
			batch_ch.ev1_x <= '0;
			batch_ch.ev1_y <= '0;
			batch_ch.ev2_x <= '0;
			batch_ch.ev2_y <= '0;
			batch_ch.ev3_x <= '0;
			batch_ch.ev3_y <= '0;
		end else begin
			if (batch_ch.valid && batch_ch.ready) begin
				predict_hotspot(cur_batch, r);
				expected_hotspots.push_back(r);
			end
			if (!batch_ch.valid || batch_ch.ready) begin
				if (pending_batches.size() != 0 && $urandom_range(99) >= send_idle) begin
					cur_batch = pending_batches.pop_front();
					batch_ch.valid <= 1'b1;
					batch_ch.ev0_x <= cur_batch.x[0];
					batch_ch.ev0_y <= cur_batch.y[0];
					batch_ch.ev1_x <= cur_batch.x[1];
					batch_ch.ev1_y <= cur_batch.y[1];
					batch_ch.ev2_x <= cur_batch.x[2];
					batch_ch.ev2_y <= cur_batch.y[2];
					batch_ch.ev3_x <= cur_batch.x[3];
					batch_ch.ev3_y <= cur_batch.y[3];
				end else begin
					batch_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		ahs_pkg::res_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_hotspots.size() == 0) begin
					report_mismatch("with nothing expected, hot_value", result_ch.hot_value, 0);
				end else begin
					want = expected_hotspots.pop_front();
					if (result_ch.motion !== want.motion)
						report_mismatch("motion", result_ch.motion, want.motion);
					if (result_ch.hot_value !== want.hot_value)
						report_mismatch("hot_value", result_ch.hot_value, want.hot_value);
					if (result_ch.hot_row !== want.hot_row)
						report_mismatch("hot_row", result_ch.hot_row, want.hot_row);
					if (result_ch.hot_col !== want.hot_col)
						report_mismatch("hot_col", result_ch.hot_col, want.hot_col);
				end
				results_seen++;
			end
			result_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic wait_drained();
		while (pending_batches.size() != 0 || batch_ch.valid || expected_hotspots.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [ahs_pkg::CFG_IDX_W-1:0] idx,
			input logic [ahs_pkg::VAL_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		case (idx)
			ahs_pkg::REG_STEP:      step_r = val;
			ahs_pkg::REG_CAP:       cap_r  = val;
			ahs_pkg::REG_THRESHOLD: thr_r  = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [ahs_pkg::VAL_W-1:0] s,
			input logic [ahs_pkg::VAL_W-1:0] c, input logic [ahs_pkg::VAL_W-1:0] t);
		write_reg(ahs_pkg::REG_STEP, s);
		write_reg(ahs_pkg::REG_CAP, c);
		write_reg(ahs_pkg::REG_THRESHOLD, t);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_uniform(input logic [ahs_pkg::COORD_W-1:0] x,
			input logic [ahs_pkg::COORD_W-1:0] y);
		ev_batch_t b;
		for (int i = 0; i < ahs_pkg::NUM_EV_IN; i++) begin
			b.x[i] = x;
			b.y[i] = y;
		end
		@(negedge clk);
		pending_batches.push_back(b);
	endtask

	task automatic queue_events(
			input logic [ahs_pkg::NUM_EV_IN*ahs_pkg::COORD_W-1:0] xs,
			input logic [ahs_pkg::NUM_EV_IN*ahs_pkg::COORD_W-1:0] ys);
		ev_batch_t b;
		for (int i = 0; i < ahs_pkg::NUM_EV_IN; i++) begin
			b.x[i] = xs[i*ahs_pkg::COORD_W +: ahs_pkg::COORD_W];
			b.y[i] = ys[i*ahs_pkg::COORD_W +: ahs_pkg::COORD_W];
		end
		@(negedge clk);
		pending_batches.push_back(b);
	endtask

	// events cluster on a hot cell most of the time so cells saturate and ties form
	task automatic queue_random(input int n);
		ev_batch_t b;
		logic [3:0] hot;
		int         mode;
		hot = 4'($urandom);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(49) == 0)
				hot = 4'($urandom);
			mode = $urandom_range(9);
			for (int i = 0; i < ahs_pkg::NUM_EV_IN; i++) begin
				if (mode == 0 || $urandom_range(3) == 0) begin
					b.x[i] = 7'($urandom);
					b.y[i] = 7'($urandom);
				end else begin
					b.x[i] = {hot[1:0], 5'($urandom)};
					b.y[i] = {hot[3:2], 5'($urandom)};
				end
			end
			@(negedge clk);
			pending_batches.push_back(b);
		end
	endtask

	task automatic run_phase(input logic [ahs_pkg::VAL_W-1:0] s,
			input logic [ahs_pkg::VAL_W-1:0] c, input logic [ahs_pkg::VAL_W-1:0] t,
			input int n, input int s_idle, input int r_idle);
		wait_drained();
		set_regs(s, c, t);
		send_idle = s_idle;
		recv_idle = r_idle;
		queue_random(n / 2);
		// hold the sender until every result of the first half is back
		wait_drained();
		queue_random(n - n / 2);
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_wdata    = '0;
		step_r       = ahs_pkg::STEP_RST;
		cap_r        = ahs_pkg::CAP_RST;
		thr_r        = ahs_pkg::THR_RST;
		mismatches   = 0;
		results_seen = 0;
		send_idle    = 24;
		recv_idle    = 84;
		for (int c = 0; c < ahs_pkg::NUM_CELLS; c++)
			grid[c] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero step from reset: all cells equal, hottest is cell 0
		write_reg(ahs_pkg::REG_STEP, 8'd0);
		@(posedge clk);
		cfg_we <= 1'b0;
		queue_uniform(7'd127, 7'd127);
		queue_events({7'd0, 7'd127, 7'd64, 7'd32}, {7'd127, 7'd0, 7'd31, 7'd96});
		wait_drained();
		// zero threshold: motion even at zero activity
		write_reg(ahs_pkg::REG_THRESHOLD, 8'd0);
		@(posedge clk);
		cfg_we <= 1'b0;
		queue_uniform(7'd0, 7'd0);
		wait_drained();
		set_regs(ahs_pkg::STEP_RST, ahs_pkg::CAP_RST, ahs_pkg::THR_RST);
		// repeated hits on the far corner climb to the cap
		for (int k = 0; k < 9; k++)
			queue_uniform(7'd127, 7'd127);
		queue_events({7'd96, 7'd95, 7'd63, 7'd31}, {7'd64, 7'd32, 7'd0, 7'd127});
		queue_events({7'd0, 7'd32, 7'd64, 7'd96}, {7'd0, 7'd0, 7'd0, 7'd0});
		queue_events({7'd127, 7'd85, 7'd42, 7'd1}, {7'd127, 7'd42, 7'd85, 7'd126});
		queue_uniform(7'd0, 7'd127);
		queue_uniform(7'd127, 7'd0);
		queue_uniform(7'd31, 7'd31);

		run_phase(ahs_pkg::STEP_RST, ahs_pkg::CAP_RST, ahs_pkg::THR_RST, 250, 24, 84);
		run_phase(8'd255, 8'd255, 8'd255, 250, 24, 84);
		// cap below what the cells already hold
		run_phase(8'd200, 8'd100, 8'd50, 250, 24, 84);
		run_phase(8'd0, 8'd255, 8'd0, 250, 84, 24);
		run_phase(8'd0, 8'd0, 8'd255, 250, 84, 24);
		run_phase(8'd1, 8'd1, 8'd1, 250, 84, 24);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 250, 0, 0);
		run_phase(8'd128, 8'd200, 8'd200, 250, 0, 0);

		wait_drained();
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
